### design/epcd_pkg.sv
// Shared types and constants for the echo pulse collision detector.
// No dependencies; imported by epcd_step and echo_pulse_collision_detector.
`timescale 1ns / 1ps
`default_nettype none

package epcd_pkg;

  // Field and state widths.
  localparam int unsigned CaptureW   = 32;
  localparam int unsigned MaxWidthW  = 16;
  localparam int unsigned SamplesW   = 4;
  localparam int unsigned ThresholdW = 9;
  localparam int unsigned SumW       = 13;
  localparam int unsigned CountW     = SamplesW;
  localparam int unsigned DistW      = 9;   // largest distance is 294
  localparam int unsigned AddrW      = 4;
  localparam int unsigned DataW      = 32;

  // Register reset values.
  localparam logic [MaxWidthW-1:0]  MaxWidthRst  = 16'd40000;
  localparam logic [SamplesW-1:0]   SamplesRst   = 4'd10;
  localparam logic [ThresholdW-1:0] ThresholdRst = 9'd20;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] RegMaxWidth  = 2'd0;
  localparam logic [1:0] RegSamples   = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  // distance = floor(100 * width / 22272). With the rounded-up reciprocal
  // below and a shift of 32 the result is exact for every 16-bit width, as
  // the accumulated rounding error stays below one step of the quotient.
  localparam int unsigned DistScale   = 100;
  localparam int unsigned DistDivisor = 48 * 58 * 8;
  localparam int unsigned DistShift   = 32;
  localparam int unsigned RecipW      = 25;
  localparam longint unsigned DistRecipL =
      ((64'(DistScale) << DistShift) + 64'(DistDivisor) - 64'd1) / 64'(DistDivisor);
  localparam logic [RecipW-1:0] DistRecip = RecipW'(DistRecipL);
  localparam int unsigned ProdW = MaxWidthW + RecipW;

  typedef struct packed {
    logic [MaxWidthW-1:0]  max_width;
    logic [SamplesW-1:0]   samples;
    logic [ThresholdW-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic                phase;
    logic [CaptureW-1:0] prev;
    logic [SumW-1:0]     sum;
    logic [CountW-1:0]   count;
  } state_t;

endpackage

`default_nettype wire

### design/echo_pulse_collision_detector.sv
// Top level of the echo pulse collision detector: stream ports, APB register
// file, input and result registers. Depends on epcd_pkg and epcd_step.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the input stream carries one 32-bit timestamp captured at
// an edge of an ultrasonic echo line. Edges alternate between rising and
// falling; on a falling edge the pulse width is checked against max_width
// (and against a timestamp that went backwards), converted to a distance of
// floor(100 * width / 22272) and accumulated. Once samples_per_decision
// good samples have been gathered (zero means sixteen), one transfer leaves
// on the output stream with bit 0 set when the average distance lies below
// distance_threshold; the accumulator then starts afresh. Rising edges and
// rejected pulses produce no output. The block takes one timestamp in every
// clock cycle unless input is held off: a timestamp is held in an input
// register and processed there in a single pass, with one constant multiplier
// for the distance, and a result is then loaded into the output register. The
// output register lets the next timestamp be taken while a result still waits;
// input is held off only when a result is pending in both the output register
// and the processing stage and the output is not being drained. Registers must
// be written over the APB port only while the block is idle; the block itself
// does not enforce this.
module echo_pulse_collision_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] capture_time
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] collision, [7:1] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import epcd_pkg::*;

  cfg_t                cfg_q, cfg_d;
  state_t              state_q, state_next;
  logic                in_valid_q, in_valid_d;
  logic [CaptureW-1:0] in_time_q;
  logic                out_valid_q, out_valid_d;
  logic                out_coll_q;
  logic                produce, collision;
  logic                advance, s_accept, cfg_write;
  logic [1:0]          reg_index;

  // ---------------------------------------------------------------------
  // Register file. Writes complete in the access phase; pready is fixed.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_index)
        RegMaxWidth:  cfg_d.max_width = pwdata[MaxWidthW-1:0];
        RegSamples:   cfg_d.samples   = pwdata[SamplesW-1:0];
        RegThreshold: cfg_d.threshold = pwdata[ThresholdW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      RegMaxWidth:  prdata = DataW'(cfg_q.max_width);
      RegSamples:   prdata = DataW'(cfg_q.samples);
      RegThreshold: prdata = DataW'(cfg_q.threshold);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_width <= MaxWidthRst;
      cfg_q.samples   <= SamplesRst;
      cfg_q.threshold <= ThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------
  // Processing stage. The held timestamp moves on unless it would produce
  // a result while the output register is full and not being drained.
  // ---------------------------------------------------------------------
  epcd_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .capture_i   (in_time_q),
    .state_o     (state_next),
    .produce_o   (produce),
    .collision_o (collision)
  );

  assign advance       = in_valid_q && (!produce || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_next;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_time_q <= s_axis_tdata;
    end
    if (advance && produce) begin
      out_coll_q <= collision;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_coll_q};

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  // A decision always clears the accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && produce) |=> (state_q.sum == '0 && state_q.count == '0))
    else $error("accumulator not cleared after a decision");

  // A rising edge never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !state_q.phase) |-> !produce)
    else $error("result produced on a rising edge");

  // Every processed timestamp becomes the previous capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.prev == $past(in_time_q)))
    else $error("previous capture not updated");

  // Input is held off only while input and output registers are both full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

### design/epcd_step.sv
// Per-edge update of the echo pulse collision detector: pulse width check,
// distance conversion, accumulation and decision. Depends on epcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epcd_step (
  input  epcd_pkg::cfg_t                  cfg_i,
  input  epcd_pkg::state_t                state_i,
  input  logic [epcd_pkg::CaptureW-1:0]   capture_i,
  output epcd_pkg::state_t                state_o,
  output logic                            produce_o,
  output logic                            collision_o
);
  import epcd_pkg::*;

  logic [CaptureW-1:0] width;
  logic                reject;
  logic [ProdW-1:0]    product;
  logic [DistW-1:0]    distance;
  logic [CountW:0]     count_inc;
  logic [CountW:0]     target;
  logic [SumW:0]       sum_wide;
  logic [SumW-1:0]     sum_new;
  logic [ThresholdW+CountW:0] limit;
  logic                decide;

  assign width    = capture_i - state_i.prev;
  assign reject   = (width > CaptureW'(cfg_i.max_width)) || (capture_i < state_i.prev);
  assign product  = ProdW'(width[MaxWidthW-1:0]) * ProdW'(DistRecip);
  assign distance = product[DistShift +: DistW];

  // A sample setting of zero stands for sixteen samples.
  assign count_inc = (CountW+1)'(state_i.count) + (CountW+1)'(1);
  assign target    = (cfg_i.samples == '0) ? (CountW+1)'(16) : (CountW+1)'(cfg_i.samples);
  assign decide    = count_inc >= target;

  assign sum_wide = (SumW+1)'(state_i.sum) + (SumW+1)'(distance);
  assign sum_new  = sum_wide[SumW-1:0];
  assign limit    = (ThresholdW+CountW+1)'(cfg_i.threshold) *
                    (ThresholdW+CountW+1)'(count_inc);

  always_comb begin
    state_o      = state_i;
    state_o.prev = capture_i;
    produce_o    = 1'b0;
    collision_o  = (ThresholdW+CountW+1)'(sum_new) < limit;
    if (!state_i.phase) begin
      // Rising edge: only the phase and the previous capture move on.
      state_o.phase = 1'b1;
    end else if (reject) begin
      // Implausible pulse: stay in the high phase so the next edge pairs up.
      state_o.phase = 1'b1;
    end else begin
      state_o.phase = 1'b0;
      if (decide) begin
        produce_o     = 1'b1;
        state_o.sum   = '0;
        state_o.count = '0;
      end else begin
        state_o.sum   = sum_new;
        state_o.count = count_inc[CountW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for echo_pulse_collision_detector: directed and random edge timestamps.
// It keeps its own model of the pulse-width filter and the distance averager.
// Depends on epcd_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;
  import epcd_pkg::*;

  // Index three has no register behind it; writes there must leave the others alone.
  localparam logic [1:0] RegSpare = 2'd3;
  // A timestamp passes through the input register into the output register;
  // the quiet after a drain covers anything still in flight.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned RandomItems   = 1050;
  localparam int unsigned SegmentItems  = RandomItems / 9;
  localparam int unsigned MaxReports    = 30;

  // Clock, reset and the stimulus side of every port, all known from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Our own copy of the registers, at their reset values.
  logic [MaxWidthW-1:0]  cfg_max_width = MaxWidthRst;
  logic [SamplesW-1:0]   cfg_samples   = SamplesRst;
  logic [ThresholdW-1:0] cfg_threshold = ThresholdRst;

  // Our own copy of the detector state.
  logic                  echo_high    = 1'b0;  // set after a rising edge
  logic [CaptureW-1:0]   last_capture = '0;
  logic [SumW-1:0]       dist_sum     = '0;
  logic [CountW-1:0]     dist_count   = '0;

  // Collision flags still owed by the block, oldest first.
  bit          expected_decisions[$];

  int unsigned src_idle_pct       = 0;
  int unsigned sink_idle_pct      = 0;
  int unsigned error_count        = 0;
  int unsigned items_sent         = 0;
  int unsigned decisions_seen     = 0;
  int unsigned collisions_seen    = 0;
  int unsigned register_writes    = 0;
  int unsigned segment_index      = 0;

  echo_pulse_collision_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] capture_time
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] collision, [7:1] zero
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // The receiver stalls at random, at a rate that each test phase chooses.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("tb: mismatch: %s", msg);
  endtask

  // Apply one accepted edge to our copy of the state. The phase toggles on
  // every edge; a falling edge whose width is too large, or whose timestamp
  // went backwards, is thrown away and the phase toggles back, so the next
  // edge is again taken as falling. Good widths become distances which are
  // summed until enough samples are in; a count already past a lowered
  // setting decides on the very next good sample.
  function automatic void predict_edge(input logic [CaptureW-1:0] stamp,
                                       output bit decided, output bit collision);
    int unsigned width;
    int unsigned distance;
    int unsigned target;
    int unsigned count_next;
    decided   = 1'b0;
    collision = 1'b0;
    echo_high = ~echo_high;
    if (!echo_high) begin
      width = stamp - last_capture;
      if (width > cfg_max_width || stamp < last_capture) begin
        echo_high = 1'b1;
      end else begin
        distance   = (DistScale * width) / DistDivisor;
        // A setting of zero means sixteen samples per decision.
        target     = (cfg_samples == '0) ? 16 : cfg_samples;
        count_next = dist_count + 1;
        dist_sum   = SumW'(dist_sum + distance);
        if (count_next >= target) begin
          decided    = 1'b1;
          // The average is compared without a division.
          collision  = (dist_sum < cfg_threshold * count_next);
          dist_sum   = '0;
          dist_count = '0;
        end else begin
          dist_count = CountW'(count_next);
        end
      end
    end
    last_capture = stamp;
  endfunction

  function automatic logic [31:0] register_value(input logic [1:0] idx);
    case (idx)
      RegMaxWidth:  return 32'(cfg_max_width);
      RegSamples:   return 32'(cfg_samples);
      RegThreshold: return 32'(cfg_threshold);
      default:      return '0;
    endcase
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that closes the access cycle. psel is then dropped before the task returns,
  // so that back-to-back calls never drive psel twice in one step.
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [3:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_registers();
    logic [31:0] word;
    for (int i = 0; i < 3; i++) begin
      apb_read({2'(i), 2'b00}, word);
      if (word !== register_value(2'(i)))
        report_mismatch($sformatf("register %0d reads %h, expected %h",
                                  i, word, register_value(2'(i))));
    end
  endtask

  // Writes one register with random junk above its field, which the block
  // must drop, then reads every register back.
  task automatic set_register(input logic [1:0] idx, input int unsigned value);
    int unsigned field_w;
    logic [31:0] word;
    case (idx)
      RegMaxWidth: begin
        cfg_max_width = MaxWidthW'(value);
        field_w = MaxWidthW;
      end
      RegSamples: begin
        cfg_samples = SamplesW'(value);
        field_w = SamplesW;
      end
      RegThreshold: begin
        cfg_threshold = ThresholdW'(value);
        field_w = ThresholdW;
      end
      default: field_w = 0;
    endcase
    word = (field_w == 0) ? $urandom() : (($urandom() << field_w) | value);
    apb_write({idx, 2'b00}, word);
    register_writes++;
    verify_registers();
  endtask

  // Hold the input stream off until every owed decision has arrived, then let
  // the pipeline settle; registers are only touched after this.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One input transfer, with a random gap in front of it. The prediction is
  // made at the edge where the transfer is accepted.
  task automatic send_capture(input logic [CaptureW-1:0] stamp);
    bit decided;
    bit collision;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_edge(stamp, decided, collision);
    items_sent++;
    if (decided) begin
      expected_decisions.push_back(collision);
    end
  endtask

  // Each transfer on the output stream is matched against the oldest owed
  // decision. Outputs are read just after the edge, so they hold the values
  // seen by the block at that edge.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected decision, tdata %h", m_axis_tdata));
      end else begin
        want = expected_decisions.pop_front();
        decisions_seen++;
        if (m_axis_tdata[0] !== want)
          report_mismatch($sformatf("decision %0d: collision %b, expected %b",
                                    decisions_seen, m_axis_tdata[0], want));
        if (m_axis_tdata[7:1] !== '0)
          report_mismatch($sformatf("decision %0d: padding bits %b",
                                    decisions_seen, m_axis_tdata[7:1]));
        if (m_axis_tdata[0] === 1'b1) collisions_seen++;
      end
    end
  end

  // Mostly well-formed pulses built on the current phase of our model, with
  // widths spread over the accepted range, bunched near the threshold, on
  // the limit and beyond it; the rest is unrelated or backward timestamps.
  function automatic logic [CaptureW-1:0] next_capture();
    int unsigned pick;
    int unsigned w;
    int unsigned centre;
    pick = $urandom_range(0, 99);
    if (pick < 6)  return $urandom();
    if (pick < 10) return last_capture - $urandom_range(1, 5000);
    if (!echo_high) return last_capture + $urandom_range(1, 4000);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w = $urandom_range(0, cfg_max_width);
    end else if (pick < 75) begin
      centre = cfg_threshold * DistDivisor / DistScale;
      w = centre + $urandom_range(0, 800);
      w = (w < 400) ? 0 : w - 400;
      if (w > cfg_max_width) w = cfg_max_width;
    end else if (pick < 85) begin
      w = cfg_max_width + $urandom_range(0, 1);
    end else if (pick < 92) begin
      w = cfg_max_width + 1 + $urandom_range(0, 100000);
    end else begin
      w = $urandom_range(0, 300);
    end
    return last_capture + w;
  endfunction

  // Register extremes are placed in the first settings of the random part;
  // later settings are drawn at random, favouring short decision windows.
  task automatic choose_setting();
    if (segment_index == 0) begin
      set_register(RegMaxWidth, 40000);
      set_register(RegSamples, 0);
      set_register(RegThreshold, $urandom_range(0, 200));
    end else if (segment_index == 1) begin
      set_register(RegMaxWidth, 0);
      set_register(RegSamples, 1);
      set_register(RegThreshold, $urandom_range(0, 511));
    end else if (segment_index == 2) begin
      set_register(RegMaxWidth, 65535);
      set_register(RegSamples, 15);
      set_register(RegThreshold, $urandom_range(0, 300));
    end else begin
      set_register(RegMaxWidth, $urandom_range(1000, 65535));
      set_register(RegSamples, ($urandom_range(0, 99) < 30) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 5));
      set_register(RegThreshold, ($urandom_range(0, 9) == 0) ? 511
                                                             : $urandom_range(0, 150));
    end
    segment_index++;
  endtask

  // Every register read and written, junk above each field ignored, and a
  // write to the spare index leaving the real registers untouched.
  task automatic test_register_access();
    verify_registers();
    set_register(RegMaxWidth, 16'hA5C3);
    set_register(RegSamples, 4'd7);
    set_register(RegThreshold, 9'h155);
    set_register(RegSpare, 0);
  endtask

  // Timer extremes, widths exactly on and just past the limit, zero width,
  // a timer wrap that looks like a short pulse, and both threshold extremes.
  task automatic test_edge_cases();
    drain_results();
    set_register(RegMaxWidth, 65535);
    set_register(RegSamples, 1);
    set_register(RegThreshold, 511);
    send_capture(32'h0000_0000);
    send_capture(32'h0000_FFFF);   // widest pulse the register allows
    send_capture(32'hFFFF_FFF0);
    send_capture(32'hFFFF_FFFF);
    send_capture(32'hFFFF_FFFF);
    send_capture(32'hFFFF_FFFF);   // zero width
    send_capture(32'hFFFF_FFF0);
    send_capture(32'h0000_0005);   // wrapped: short width, but time went backwards
    send_capture(32'h0001_0005);   // one tick too wide
    send_capture(32'h0001_0069);
    drain_results();
    set_register(RegMaxWidth, 1000);
    set_register(RegThreshold, 0);
    send_capture(32'h5555_5555);
    send_capture(32'h5555_5555 + 1000);
    send_capture(32'hAAAA_AAAA);
    send_capture(32'hAAAA_AAAA + 1001);
    send_capture(32'hAAAA_AAAA + 2001);
  endtask

  // Samples gathered under a long window, then the window shortened below
  // the count already held: the next good sample must decide on all of them.
  task automatic test_window_lowered();
    logic [CaptureW-1:0] t;
    drain_results();
    set_register(RegMaxWidth, 65535);
    set_register(RegSamples, 10);
    set_register(RegThreshold, 100);
    if (echo_high) send_capture(last_capture);   // realign to a rising edge
    t = 32'h1000_0000;
    send_capture(t);
    send_capture(t + 20000);
    send_capture(t + 100000);
    send_capture(t + 130000);
    send_capture(t + 200000);
    send_capture(t + 200500);
    drain_results();
    set_register(RegSamples, 1);
    send_capture(t + 300000);
    send_capture(t + 340000);
  endtask

  // One idling regime of the random part, run as segments of fixed length,
  // each under its own register setting and preceded by a full drain.
  task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned regime_items;
    regime_items = 0;
    drain_results();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (regime_items + SegmentItems <= RandomItems / 3) begin
      drain_results();
      choose_setting();
      repeat (SegmentItems) begin
        send_capture(next_capture());
        regime_items++;
        // Now and then the sender waits for every owed decision.
        if ($urandom_range(0, 119) == 0) drain_results();
      end
    end
  endtask

  initial begin
    src_idle_pct  = 37;
    sink_idle_pct = 87;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_edge_cases();
    test_window_lowered();
    test_random_stream(37, 87);
    test_random_stream(87, 37);
    test_random_stream(0, 0);
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d timestamps sent, %0d decisions checked (%0d collisions)",
             items_sent, decisions_seen, collisions_seen);
    $display("summary: %0d register writes across %0d random settings, %0d mismatches",
             register_writes, segment_index, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with the longest stalls.
  initial begin
    #2000000;
    $display("tb: timeout with %0d decisions outstanding", expected_decisions.size());
    $display("tb: errors");
    $finish;
  end

endmodule

### filelist.f
design/epcd_pkg.sv
design/epcd_step.sv
design/echo_pulse_collision_detector.sv
dv/tb.sv
